// ----- sv/circle_rasterizer_unit_macros.svh -----
// Assertion macros shared by the circle rasterizer modules.
`ifndef CIRCLE_RASTERIZER_UNIT_MACROS_SVH
`define CIRCLE_RASTERIZER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRAST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRAST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/crast_pkg.sv -----
// Shared types and constants of the circle rasterizer.
package crast_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_PITCH  = 1'b0,
    REG_PIXEL_BYTES = 1'b1
  } cfg_reg_t;

  localparam int PITCH_W  = 15;
  localparam int PBYTES_W = 3;
  localparam logic [PITCH_W-1:0]  PITCH_RESET  = 15'd7680;
  localparam logic [PBYTES_W-1:0] PBYTES_RESET = 3'd4;

  localparam int IN_COORD_W = 12;
  localparam int RADIUS_W   = 11;
  localparam int COLOR_W    = 32;
  localparam int PIX_W      = 14;
  localparam int OFF_W      = 29;
  localparam int DEC_W      = 16;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 96;

  localparam logic signed [DEC_W-1:0] DEC_INIT       = 16'sd3;
  localparam logic signed [DEC_W-1:0] DEC_STEP_DIAG  = 16'sd10;
  localparam logic signed [DEC_W-1:0] DEC_STEP_AXIAL = 16'sd6;

  localparam int MIRROR_W = 3;
  localparam logic [MIRROR_W-1:0] MIRROR_LAST = 3'd7;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic done;
  } pix_ctl_t;

endpackage

// ----- sv/crast_queue.sv -----
// Small FIFO of octant points between the step engine and the pixel writer.
`include "circle_rasterizer_unit_macros.svh"

module crast_queue import crast_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output q_stat_t      stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));

  `CRAST_ASSERT_NOW(a_q_no_overflow, push && stat.full, pop, "push into full point queue")
  `CRAST_ASSERT_NOW(a_q_no_underflow, pop, !stat.empty, "pop from empty point queue")

endmodule

// ----- sv/crast_front.sv -----
// Front end: accept items, run the midpoint step and queue octant points.
`include "circle_rasterizer_unit_macros.svh"

module crast_front import crast_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int JOB_W      = 2 * 12 + 2 * 12 + COLOR_W + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  q_stat_t               q_stat,
  output logic                  push,
  output logic [JOB_W-1:0]      job
);

  localparam int CW       = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int CY_LSB   = IN_COORD_W;
  localparam int RAD_LSB  = 2 * IN_COORD_W;
  localparam int COL_LSB  = RAD_LSB + RADIUS_W;

  logic [CW-1:0]                cx_r, cx_nxt;
  logic [CW-1:0]                cy_r, cy_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt;
  logic signed [COORD_BITS-1:0] y_r, y_nxt;
  logic signed [COORD_BITS-1:0] rad_s;
  logic signed [DEC_W-1:0]      dec_r, dec_nxt;
  logic [COLOR_W-1:0]           color_r, color_nxt;
  logic                         active_r, active_nxt;
  logic                         accept;
  op_t                          op;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign rad_s     = COORD_BITS'(in_tdata[RAD_LSB +: RADIUS_W]);

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    color_nxt  = color_r;
    active_nxt = active_r;
    push       = 1'b0;
    if (accept) begin
      if (op == OP_START) begin
        cx_nxt    = in_tdata[CW-1:0];
        cy_nxt    = in_tdata[CY_LSB +: CW];
        color_nxt = in_tdata[COL_LSB +: COLOR_W];
        x_nxt     = '0;
        y_nxt     = rad_s;
        dec_nxt   = DEC_INIT - (DEC_W'(rad_s) <<< 1);
        push      = 1'b1;
      end else if (active_r) begin
        x_nxt = x_r + 1'b1;
        if (dec_r > 0) begin
          y_nxt   = y_r - 1'b1;
          dec_nxt = dec_r + ((DEC_W'(x_nxt) - DEC_W'(y_nxt)) <<< 2) + DEC_STEP_DIAG;
        end else begin
          dec_nxt = dec_r + (DEC_W'(x_nxt) <<< 2) + DEC_STEP_AXIAL;
        end
        push = 1'b1;
      end
      if (push) begin
        active_nxt = (y_nxt >= x_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      x_r      <= '0;
      y_r      <= '0;
      dec_r    <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      dec_r    <= dec_nxt;
      color_r  <= color_nxt;
      active_r <= active_nxt;
    end
  end

  // the done flag rides with the point so the writer can tag the eighth pixel
  assign job = {color_nxt, !active_nxt, y_nxt, x_nxt, cy_nxt, cx_nxt};

  `CRAST_ASSERT_NOW(a_start_queues, accept && op == OP_START, push, "start item queued no point")

endmodule

// ----- sv/crast_back.sv -----
// Back end: mirror each queued point eight ways and compute the byte offsets.
`include "circle_rasterizer_unit_macros.svh"

module crast_back import crast_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int JOB_W      = 2 * 12 + 2 * 12 + COLOR_W + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  q_stat_t               q_stat,
  input  logic [JOB_W-1:0]      q_job,
  output logic                  pop,
  input  logic [PITCH_W-1:0]    pitch,
  input  logic [PBYTES_W-1:0]   pbytes,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_px,
  output logic [PIX_W-1:0]      out_py,
  output logic [OFF_W-1:0]      out_off,
  output logic [COLOR_W-1:0]    out_color,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  localparam int CW = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int PW = ((CW > COORD_BITS) ? CW : COORD_BITS) + 2;

  logic [CW-1:0]                j_cx, j_cy;
  logic signed [COORD_BITS-1:0] j_x, j_y;
  logic                         j_done;
  logic [COLOR_W-1:0]           j_color;

  logic [CW-1:0]                cx_r, cy_r;
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic                         done_r;
  logic [COLOR_W-1:0]           color_r;
  logic [MIRROR_W-1:0]          k_r;
  logic                         busy_r;

  logic                         en;
  logic signed [COORD_BITS-1:0] a_sel, b_sel;
  logic signed [PW-1:0]         cxw, cyw, aw, bw, px, py;

  pix_ctl_t                     s1_ctl_r, s2_ctl_r;
  logic signed [PW-1:0]         s1_px_r, s1_py_r;
  logic [COLOR_W-1:0]           s1_color_r, s2_color_r;
  logic [PIX_W-1:0]             s2_px_r, s2_py_r;
  logic [OFF_W-1:0]             s2_prod_y_r, s2_prod_x_r;
  logic signed [PITCH_W:0]      pitch_s;
  logic signed [PBYTES_W:0]     pb_s;

  pix_ctl_t                     out_ctl_r;
  logic [PIX_W-1:0]             out_px_r, out_py_r;
  logic [OFF_W-1:0]             out_off_r;
  logic [COLOR_W-1:0]           out_color_r;

  assign {j_color, j_done, j_y, j_x, j_cy, j_cx} = q_job;

  // advance the whole pipeline unless the output register is held
  assign en  = !out_ctl_r.valid || out_tready;
  assign pop = en && !q_stat.empty && (!busy_r || k_r == MIRROR_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (en) begin
      if (pop) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r && k_r == MIRROR_LAST) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx_r    <= j_cx;
      cy_r    <= j_cy;
      x_r     <= j_x;
      y_r     <= j_y;
      done_r  <= j_done;
      color_r <= j_color;
    end
  end

  // bit 2 swaps the axes, bit 0 negates the column term, bit 1 the row term
  always_comb begin
    a_sel = k_r[2] ? y_r : x_r;
    b_sel = k_r[2] ? x_r : y_r;
    cxw   = PW'(cx_r);
    cyw   = PW'(cy_r);
    aw    = PW'(a_sel);
    bw    = PW'(b_sel);
    px    = k_r[0] ? (cxw - aw) : (cxw + aw);
    py    = k_r[1] ? (cyw - bw) : (cyw + bw);
  end

  assign pitch_s = {1'b0, pitch};
  assign pb_s    = {1'b0, pbytes};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r  <= '0;
      s2_ctl_r  <= '0;
      out_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r.valid <= busy_r;
      s1_ctl_r.last  <= (k_r == MIRROR_LAST);
      s1_ctl_r.done  <= done_r && (k_r == MIRROR_LAST);
      s2_ctl_r       <= s1_ctl_r;
      out_ctl_r      <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r     <= px;
      s1_py_r     <= py;
      s1_color_r  <= color_r;
      s2_px_r     <= PIX_W'(s1_px_r);
      s2_py_r     <= PIX_W'(s1_py_r);
      s2_prod_y_r <= OFF_W'(s1_py_r * pitch_s);
      s2_prod_x_r <= OFF_W'(s1_px_r * pb_s);
      s2_color_r  <= s1_color_r;
      out_px_r    <= s2_px_r;
      out_py_r    <= s2_py_r;
      out_off_r   <= s2_prod_y_r + s2_prod_x_r;
      out_color_r <= s2_color_r;
    end
  end

  assign out_tvalid = out_ctl_r.valid;
  assign out_tlast  = out_ctl_r.last;
  assign out_tuser  = out_ctl_r.done;
  assign out_px     = out_px_r;
  assign out_py     = out_py_r;
  assign out_off    = out_off_r;
  assign out_color  = out_color_r;

  `CRAST_ASSERT_NOW(a_pop_at_run_end, pop, !busy_r || k_r == MIRROR_LAST, "point taken mid run")
  `CRAST_ASSERT_NEXT(a_run_continues, busy_r && en && k_r != MIRROR_LAST, busy_r, "run cut short")

endmodule

// ----- sv/circle_rasterizer_unit.sv -----
// Top level of the midpoint circle rasterizer: config registers and wiring.
// An accepted item's point passes through the point queue, the run registers, stages s1 and s2 and the output register.
// Each start or step item yields eight pixel writes, one pixel write per cycle from the mirror
// sequencer while out_tready does not hold the output; a step on an idle circle writes nothing.
// A two-entry point queue lets new items be accepted while a run is still being written.
// Reset: synchronous, active low; circle goes idle, pitch 7680, 4 bytes per pixel.
module circle_rasterizer_unit import crast_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // center_x, center_y, radius, draw_color, zero pad
  input  logic                   in_tuser,   // op
  // pixel writes
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // pixel_x, pixel_y, byte_offset, pixel_value, pad
  output logic                   out_tlast,  // last_of_step
  output logic                   out_tuser,  // circle_done
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PITCH_W-1:0]     cfg_data
);

  localparam int CW      = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
  localparam int JOB_W   = 2 * CW + 2 * COORD_BITS + 1 + COLOR_W;
  localparam int PAD_W   = OUT_TDATA_W - (2 * PIX_W + OFF_W + COLOR_W);
  localparam int Q_DEPTH = 2;

  logic [PITCH_W-1:0]  pitch_r;
  logic [PBYTES_W-1:0] pbytes_r;

  q_stat_t             q_stat;
  logic                push, pop;
  logic [JOB_W-1:0]    push_job, pop_job;

  logic [PIX_W-1:0]    px, py;
  logic [OFF_W-1:0]    off;
  logic [COLOR_W-1:0]  color;

  // Config writes land at once; the user must see they only happen while the block is idle, unenforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r  <= PITCH_RESET;
      pbytes_r <= PBYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_PITCH:  pitch_r  <= cfg_data;
        REG_PIXEL_BYTES: pbytes_r <= cfg_data[PBYTES_W-1:0];
        default:         pitch_r  <= pitch_r;
      endcase
    end
  end

  // Front: holds the circle state and queues one octant point per start item or per step item on an active circle.
  crast_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // Queue: decouples point generation from the writer, which sends one pixel per cycle unless the output is held.
  crast_queue #(
    .W     (JOB_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_job),
    .pop   (pop),
    .dout  (pop_job),
    .stat  (q_stat)
  );

  // Back: eight mirrored writes per point, offset multiply, output register.
  crast_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_job      (pop_job),
    .pop        (pop),
    .pitch      (pitch_r),
    .pbytes     (pbytes_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_px     (px),
    .out_py     (py),
    .out_off    (off),
    .out_color  (color),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Pack the write fields, lowest first.
  assign out_tdata = {{PAD_W{1'b0}}, color, off, py, px};

endmodule
